// ----- rtl/gfc_pkg.sv -----
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared widths, codes and controller states of the greedy graph colorer.
// ----------------------------------------------------------------------------
package gfc_pkg;

  // Fixed field widths of the stream beats
  localparam int VERTEX_W      = 10;
  localparam int COLOR_FIELD_W = 6;
  localparam int COUNT_FIELD_W = 7;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 1;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_COLORS   = 64;

  // Largest vertex store the 10-bit index can reach
  localparam int VERTEX_SPAN = 1 << VERTEX_W;

  // Colors examined per cycle by the free-color search
  localparam int SEARCH_CHUNK_W   = 8;
  localparam int SEARCH_CHUNK_LOG = 3;

  // Operation codes
  localparam logic OP_ADJ   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_RUN,
    ST_SEARCH,
    ST_FINISH
  } gfc_state_t;

endpackage

// ----- rtl/greedy_first_fit_graph_coloring.sv -----
// ----------------------------------------------------------------------------
// greedy_first_fit_graph_coloring
// Non-last adjacency beat: taken back to back.
// Last beat of a vertex: input held off through the free-color search, 1 to
// ceil(MAX_COLORS/8) steps, and the result write; result is registered.
// Clear beat and reset: clearing pass over all min(MAX_VERTICES,1024) entries
// of the vertex store, one entry a cycle, with the input held off.
// ----------------------------------------------------------------------------
module greedy_first_fit_graph_coloring #(
  parameter int MAX_VERTICES = gfc_pkg::DEF_MAX_VERTICES,
  parameter int MAX_COLORS   = gfc_pkg::DEF_MAX_COLORS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [9:0] vertex, [19:10] neighbor, [23:20] zero
  input  logic [gfc_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] op, [1] has_neighbor
  input  logic [gfc_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [9:0] colored_vertex, [15:10] assigned_color, [22:16] colors_used, [23] zero
  output logic [gfc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] no_free_color
  output logic [gfc_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import gfc_pkg::*;

  localparam int DEPTH = (MAX_VERTICES < VERTEX_SPAN) ? MAX_VERTICES : VERTEX_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_COLORS);
  localparam int CNT_W = $clog2(MAX_COLORS + 1);
  localparam int DW    = CW + 1;

  gfc_state_t state_r, state_nxt;

  logic [AW-1:0]         clr_cnt_r;
  logic                  clr_last;
  logic                  s1_valid_r;
  logic                  s1_op_r;
  logic                  s1_last_r;
  logic                  s1_hit_r;
  logic [VERTEX_W-1:0]   s1_vertex_r;
  logic [VERTEX_W-1:0]   cur_vertex_r;
  logic [MAX_COLORS-1:0] mask_r, mask_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  res_found_r;
  logic [CW-1:0]         res_color_r;
  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  logic [VERTEX_W-1:0] in_vertex;
  logic [VERTEX_W-1:0] in_neighbor;
  logic                in_accept;
  logic                nb_ok;
  logic                v_ok;
  logic                out_free;
  logic                commit;
  logic                srch_start;
  logic                srch_done;
  logic                srch_found;
  logic [CW-1:0]       srch_color;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [DW-1:0]       mem_wdata;
  logic [DW-1:0]       rd_word;
  logic [CW-1:0]       res_color_out;

  assign in_vertex   = in_tdata[VERTEX_W-1:0];
  assign in_neighbor = in_tdata[2*VERTEX_W-1:VERTEX_W];
  assign in_accept   = in_tvalid && in_tready;
  assign nb_ok       = ({22'd0, in_neighbor} < 32'(MAX_VERTICES));
  assign v_ok        = ({22'd0, cur_vertex_r} < 32'(MAX_VERTICES));
  assign clr_last    = (clr_cnt_r == AW'(DEPTH - 1));
  assign out_free    = !out_valid_r || out_tready;
  assign res_color_out = res_found_r ? res_color_r : '0;

  gfc_color_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (in_neighbor[AW-1:0]),
    .rdata (rd_word)
  );

  gfc_search #(
    .MAX_COLORS (MAX_COLORS),
    .CW         (CW)
  ) u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .mask  (mask_r),
    .done  (srch_done),
    .found (srch_found),
    .color (srch_color)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (s1_valid_r && s1_op_r == OP_CLEAR) begin
          state_nxt = ST_CLEAR;
        end else if (s1_valid_r && s1_last_r) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_tready  = 1'b0;
    srch_start = 1'b0;
    commit     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_cnt_r;
    mem_wdata  = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_RUN: begin
        // hold off the next beat behind a last or clear beat
        in_tready  = !(s1_valid_r && (s1_op_r == OP_CLEAR || s1_last_r));
        srch_start = s1_valid_r && s1_op_r == OP_ADJ && s1_last_r;
      end
      ST_SEARCH: begin
      end
      ST_FINISH: begin
        commit    = out_free;
        mem_we    = out_free && v_ok;
        mem_waddr = cur_vertex_r[AW-1:0];
        mem_wdata = {res_found_r, res_color_out};
      end
      default: begin
      end
    endcase
  end

  // Mask and color count
  always_comb begin
    mask_nxt  = mask_r;
    count_nxt = count_r;
    if (state_r == ST_RUN && s1_valid_r) begin
      if (s1_op_r == OP_CLEAR) begin
        mask_nxt  = '0;
        count_nxt = '0;
      end else if (s1_hit_r && rd_word[CW]) begin
        mask_nxt[rd_word[CW-1:0]] = 1'b1;
      end
    end else if (commit) begin
      mask_nxt = '0;
      if (res_found_r && (CNT_W'(res_color_r) + CNT_W'(1) > count_r)) begin
        count_nxt = CNT_W'(res_color_r) + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      mask_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= in_accept;
      mask_r     <= mask_nxt;
      count_r    <= count_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end else begin
        clr_cnt_r <= '0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r     <= in_tuser[0];
      s1_last_r   <= in_tlast;
      s1_vertex_r <= in_vertex;
      s1_hit_r    <= in_tuser[1] && (in_neighbor != in_vertex) && nb_ok;
    end
    if (srch_start) begin
      cur_vertex_r <= s1_vertex_r;
    end
    if (state_r == ST_SEARCH && srch_done) begin
      res_found_r <= srch_found;
      res_color_r <= srch_color;
    end
    if (commit) begin
      out_data_r <= {1'b0, COUNT_FIELD_W'(count_nxt), COLOR_FIELD_W'(res_color_out),
                     cur_vertex_r};
      out_user_r <= !res_found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_ready_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_RUN))
    else $error("input ready outside the run state");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> !mem_we)
    else $error("store write overlaps an accepted beat");

  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tlast) |=> !in_tready)
    else $error("beat accepted right behind a last beat");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finish step");
`endif

endmodule

// ----- rtl/gfc_color_mem.sv -----
// ----------------------------------------------------------------------------
// gfc_color_mem
// Per-vertex store of {colored flag, color}; one write and one registered read.
// ----------------------------------------------------------------------------
module gfc_color_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/gfc_search.sv -----
// ----------------------------------------------------------------------------
// gfc_search
// Iterative first-free-color finder: scans the used-color mask one chunk a cycle.
// ----------------------------------------------------------------------------
module gfc_search #(
  parameter int MAX_COLORS = 64,
  parameter int CW         = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MAX_COLORS-1:0] mask,
  output logic                  done,
  output logic                  found,
  output logic [CW-1:0]         color
);
  import gfc_pkg::*;

  localparam int SW   = SEARCH_CHUNK_W;
  localparam int NCH  = (MAX_COLORS + SW - 1) / SW;
  localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PADW = NCH * SW;

  logic            busy_r;
  logic [CHW-1:0]  ch_r;
  logic [PADW-1:0] pad;
  logic [SW-1:0]   chunk;
  logic [SEARCH_CHUNK_LOG-1:0] pos;
  logic            hit;
  logic            last_chunk;

  // Padding colors count as used so they are never picked
  always_comb begin
    pad = '1;
    pad[MAX_COLORS-1:0] = mask;
  end

  assign chunk      = pad[ch_r*SW +: SW];
  assign hit        = ~&chunk;
  assign last_chunk = (ch_r == CHW'(NCH - 1));

  always_comb begin
    pos = '0;
    for (int i = SW - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        pos = SEARCH_CHUNK_LOG'(i);
      end
    end
  end

  assign done  = busy_r && (hit || last_chunk);
  assign found = hit;
  assign color = CW'({ch_r, pos});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ch_r   <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      ch_r   <= '0;
    end else if (busy_r) begin
      if (hit || last_chunk) begin
        busy_r <= 1'b0;
      end else begin
        ch_r <= ch_r + CHW'(1);
      end
    end
  end

endmodule

// ----- test/greedy_first_fit_graph_coloring_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_first_fit_graph_coloring_test
// Streams adjacency beats into the colorer and checks every coloring it
// reports against a first-fit predictor kept in step with the stream, or
// against a directed row's expected values. A short directed sequence covers
// field extremes and the ignore rules. A clique build then drives the color
// count up. Random vertices with random stalls on both sides finish the run.
// ----------------------------------------------------------------------------
module greedy_first_fit_graph_coloring_test;
  import gfc_pkg::*;

  localparam int NUM_COLORS    = DEF_MAX_COLORS;
  localparam int NUM_VERTICES  = DEF_MAX_VERTICES;
  localparam int RANDOM_BEATS  = 410;
  localparam int CLIQUE_BASE   = 100;
  localparam int CLIQUE_SIZE   = 16;
  localparam int LINGER_CYCLES = 1100;

  typedef struct packed {
    logic                 op;
    logic [VERTEX_W-1:0]  vertex;
    logic [VERTEX_W-1:0]  neighbor;
    logic                 has_nb;
    logic                 last;
  } adj_beat_t;

  typedef struct packed {
    logic [VERTEX_W-1:0]      vertex;
    logic [COLOR_FIELD_W-1:0] color;
    logic [COUNT_FIELD_W-1:0] count;
    logic                     no_free;
  } coloring_t;

  typedef struct {
    adj_beat_t beat;
    bit        typed;
    coloring_t want;
  } dir_row_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  // [9:0] vertex, [19:10] neighbor, [23:20] zero
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  // [0] op, [1] has_neighbor
  logic [IN_TUSER_W-1:0]   in_tuser   = '0;
  logic                    in_tlast   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // [9:0] colored_vertex, [15:10] assigned_color, [22:16] colors_used, [23] zero
  logic [OUT_TDATA_W-1:0]  out_tdata;
  // [0] no_free_color
  logic [OUT_TUSER_W-1:0]  out_tuser;

  // Predictor state
  logic [COLOR_FIELD_W-1:0] shade   [NUM_VERTICES];
  bit                       painted [NUM_VERTICES];
  bit [NUM_COLORS-1:0]      taken_colors = '0;
  int                       color_count  = 0;

  coloring_t pending_colorings [$];
  dir_row_t  directed [$];

  bit steady = 1'b0;
  int errors = 0;
  int beats_sent = 0;
  int clears_sent = 0;
  int colorings_checked = 0;
  int no_free_seen = 0;
  int peak_count = 0;

  greedy_first_fit_graph_coloring DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 8);
  end

  function automatic adj_beat_t adj(input int v, input int nb, input bit has, input bit last);
    adj_beat_t b;
    b.op = OP_ADJ;
    b.vertex = v[VERTEX_W-1:0];
    b.neighbor = nb[VERTEX_W-1:0];
    b.has_nb = has;
    b.last = last;
    return b;
  endfunction

  function automatic dir_row_t dir_row(input adj_beat_t b, input bit typed, input int col,
                                       input int cnt);
    dir_row_t r;
    r.beat = b;
    r.typed = typed;
    r.want.vertex = b.vertex;
    r.want.color = col[COLOR_FIELD_W-1:0];
    r.want.count = cnt[COUNT_FIELD_W-1:0];
    r.want.no_free = 1'b0;
    return r;
  endfunction

  function automatic void add_row(input dir_row_t r);
    directed = {directed, r};
  endfunction

  function automatic adj_beat_t clear_beat();
    adj_beat_t b;
    b = adj($urandom_range(1023), $urandom_range(1023), 1'($urandom_range(1)),
            1'($urandom_range(1)));
    b.op = OP_CLEAR;
    return b;
  endfunction

  function automatic int pick_vertex();
    return ($urandom_range(99) < 15) ? $urandom_range(1023) : $urandom_range(47);
  endfunction

  // First-fit coloring of one beat; returns 1 when the beat yields a coloring.
  function automatic bit predict_coloring(input adj_beat_t b, output coloring_t r);
    int c;
    r = '0;
    if (b.op == OP_CLEAR) begin
      foreach (painted[i]) painted[i] = 1'b0;
      taken_colors = '0;
      color_count = 0;
      return 1'b0;
    end
    if (b.has_nb && b.neighbor != b.vertex && painted[b.neighbor])
      taken_colors[shade[b.neighbor]] = 1'b1;
    if (!b.last)
      return 1'b0;
    c = NUM_COLORS;
    for (int i = NUM_COLORS - 1; i >= 0; i--)
      if (!taken_colors[i]) c = i;
    r.vertex = b.vertex;
    if (c < NUM_COLORS) begin
      shade[b.vertex] = c[COLOR_FIELD_W-1:0];
      painted[b.vertex] = 1'b1;
      if (c + 1 > color_count) color_count = c + 1;
      r.color = c[COLOR_FIELD_W-1:0];
    end else begin
      painted[b.vertex] = 1'b0;
      r.no_free = 1'b1;
    end
    r.count = color_count[COUNT_FIELD_W-1:0];
    taken_colors = '0;
    return 1'b1;
  endfunction

  task automatic send_beat(input adj_beat_t b, input bit typed, input coloring_t want);
    coloring_t r;
    bit got;
    while (!steady && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - 2 * VERTEX_W){1'b0}}, b.neighbor, b.vertex};
    in_tuser <= {b.has_nb, b.op};
    in_tlast <= b.last;
    do @(posedge clk); while (!in_tready);
    got = predict_coloring(b, r);
    if (got) pending_colorings = {pending_colorings, (typed ? want : r)};
    beats_sent++;
    if (b.op == OP_CLEAR) clears_sent++;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    coloring_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_colorings.size() == 0) begin
        errors++;
        $display("%0t: unexpected coloring beat, vertex %0d", $time,
                 out_tdata[VERTEX_W-1:0]);
      end else begin
        want = pending_colorings.pop_front();
        check_field("colored_vertex", int'(want.vertex), int'(out_tdata[9:0]));
        check_field("assigned_color", int'(want.color), int'(out_tdata[15:10]));
        check_field("colors_used", int'(want.count), int'(out_tdata[22:16]));
        check_field("no_free_color", int'(want.no_free), int'(out_tuser[0]));
        colorings_checked++;
        if (out_tuser[0]) no_free_seen++;
        if (int'(out_tdata[22:16]) > peak_count) peak_count = int'(out_tdata[22:16]);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("greedy_first_fit_graph_coloring_test failed");
    $finish;
  end

  initial begin
    adj_beat_t b;
    int random_start;
    int v;
    int len;
    foreach (shade[i]) shade[i] = '0;
    foreach (painted[i]) painted[i] = 1'b0;

    // Directed rows: ignore rules, recoloring, clears mid-vertex, extremes
    add_row(dir_row(adj(0, 0, 0, 1), 1, 0, 1));         // isolated vertex
    add_row(dir_row(adj(1023, 0, 1, 1), 1, 1, 2));
    add_row(dir_row(adj(5, 5, 1, 0), 0, 0, 0));         // self-loop
    add_row(dir_row(adj(5, 1023, 1, 1), 1, 0, 2));
    add_row(dir_row(adj(6, 700, 1, 0), 0, 0, 0));       // uncolored neighbor
    add_row(dir_row(adj(6, 0, 0, 0), 0, 0, 0));         // edge flag clear
    add_row(dir_row(adj(6, 5, 1, 1), 0, 0, 0));
    add_row(dir_row(adj(7, 0, 1, 0), 0, 0, 0));
    add_row(dir_row(adj(7, 1023, 1, 0), 0, 0, 0));
    add_row(dir_row(adj(7, 6, 1, 1), 1, 2, 3));
    add_row(dir_row(adj(0, 7, 1, 1), 0, 0, 0));         // recolor
    add_row(dir_row(adj(9, 1023, 1, 0), 0, 0, 0));
    b = adj(1023, 1023, 1, 1);
    b.op = OP_CLEAR;
    add_row(dir_row(b, 0, 0, 0));                       // clear mid-vertex
    add_row(dir_row(adj(9, 0, 0, 1), 1, 0, 1));
    add_row(dir_row(adj(1023, 9, 1, 1), 1, 1, 2));
    add_row(dir_row(adj(682, 341, 1, 0), 0, 0, 0));
    add_row(dir_row(adj(682, 1023, 1, 1), 0, 0, 0));
    add_row(dir_row(adj(341, 682, 1, 1), 0, 0, 0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_beat(directed[i].beat, directed[i].typed, directed[i].want);

    // Hold the sender until the directed colorings are all back
    in_tvalid <= 1'b0;
    while (pending_colorings.size() != 0) @(posedge clk);

    // Clique build: vertex k sees colors 0..k-1 and takes color k
    send_beat(clear_beat(), 0, '0);
    for (int k = 0; k < CLIQUE_SIZE; k++) begin
      if (k == 0)
        send_beat(adj(CLIQUE_BASE, 0, 0, 1), 0, '0);
      else
        for (int j = 0; j < k; j++)
          send_beat(adj(CLIQUE_BASE + k, CLIQUE_BASE + j, 1, j == k - 1), 0, '0);
    end
    // A neighbor holding the top color leaves color 0 free
    send_beat(adj(300, CLIQUE_BASE + CLIQUE_SIZE - 1, 1, 1), 0, '0);

    random_start = beats_sent;
    while (beats_sent < random_start + RANDOM_BEATS) begin
      steady <= (beats_sent - random_start >= 200) && (beats_sent - random_start < 350);
      case ($urandom_range(99)) inside
        [0:2]: send_beat(clear_beat(), 0, '0);
        [3:7]: send_beat(adj($urandom_range(1023), $urandom_range(1023),
                             1'($urandom_range(1)), 1'($urandom_range(1))), 0, '0);
        default: begin
          v = pick_vertex();
          len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
          for (int j = 0; j < len; j++)
            send_beat(adj(v, ($urandom_range(99) < 8) ? v : pick_vertex(),
                          $urandom_range(99) >= 10, j == len - 1), 0, '0);
        end
      endcase
    end

    in_tvalid <= 1'b0;
    steady <= 1'b0;
    while (pending_colorings.size() != 0) @(posedge clk);
    // Trailing clear pass may still run; catch any stray coloring
    repeat (LINGER_CYCLES) @(posedge clk);

    $display("%0d beats sent, %0d of them clears; %0d colorings checked",
             beats_sent, clears_sent, colorings_checked);
    $display("peak color count %0d, %0d vertices found no free color",
             peak_count, no_free_seen);
    if (errors == 0) begin
      $display("greedy_first_fit_graph_coloring_test passed");
    end else begin
      $display("greedy_first_fit_graph_coloring_test failed");
    end
    $finish;
  end

endmodule

// ----- greedy_first_fit_graph_coloring.f -----
rtl/gfc_pkg.sv
rtl/gfc_color_mem.sv
rtl/gfc_search.sv
rtl/greedy_first_fit_graph_coloring.sv
test/greedy_first_fit_graph_coloring_test.sv
